@@ src/jlt_pkg.sv @@
// Shared types and constants for the jerk-limited joint tracker.
`default_nettype none
package jlt_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TICK = 2'd1,
    KIND_STOP = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_TICK_PERIOD  = 3'd0,
    REG_OMEGA        = 3'd1,
    REG_SPEED_FIRST  = 3'd2,
    REG_SPEED_OTHER  = 3'd3,
    REG_ACCEL_FIRST  = 3'd4,
    REG_ACCEL_OTHER  = 3'd5,
    REG_ACCEL_CHANGE = 3'd6,
    REG_STEP_LIMIT   = 3'd7
  } reg_e;

  // Sequencer steps for one joint. ST_CHECK and each ST_MUL step use the shared multiplier once.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_P,
    ST_MUL_WV,
    ST_MUL_WP,
    ST_DESIRED,
    ST_MUL_AT,
    ST_VEL,
    ST_MUL_VT,
    ST_STEP,
    ST_EMIT
  } state_e;

  localparam int unsigned SettleEps = 10;
  localparam int unsigned VelEps    = 102;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

endpackage
`default_nettype wire

@@ src/jlt_if.sv @@
// Valid/ready channel interfaces for items, results and configuration writes.
`default_nettype none
interface jlt_in_if #(parameter int unsigned AngleWidth = 24);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [2:0]                   joint;
  logic signed [AngleWidth-1:0] target_pos;
  logic signed [AngleWidth-1:0] current_pos;
  logic                         continuous;
  logic                         last_joint;
  logic                         link_ok;
  modport source (output valid, kind, joint, target_pos, current_pos, continuous,
                  last_joint, link_ok, input ready);
  modport sink (input valid, kind, joint, target_pos, current_pos, continuous,
                last_joint, link_ok, output ready);
endinterface

interface jlt_out_if #(parameter int unsigned AngleWidth = 24);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   out_joint;
  logic signed [AngleWidth-1:0] command_pos;
  logic                         status;
  logic                         at_target;
  logic                         motion_active;
  logic                         last;
  modport source (output valid, out_joint, command_pos, status, at_target,
                  motion_active, last, input ready);
  modport sink (input valid, out_joint, command_pos, status, at_target,
                motion_active, last, output ready);
endinterface

interface jlt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [jlt_pkg::CfgIdxW-1:0]   index;
  logic [jlt_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/jerk_limited_joint_tracker.sv @@
// Top level of the jerk-limited joint tracker with its sequencer and shared multiplier.
`default_nettype none
// Load, stop and ignored items are taken in the idle state and may follow back to back.
// A tick while active walks the joints in turn, through every sequencer step for a
// moving joint and from ST_CHECK straight to ST_EMIT for a settled one, then sends one
// result beat per joint; output stalls can delay the last beat, and input is held off
// until it has gone. The shared multiplier is used six times per moving joint. Reset is
// asynchronous: it clears joint state, flags and datapath registers, and presets config.
module jerk_limited_joint_tracker #(
  parameter int unsigned JOINT_COUNT = 6,
  parameter int unsigned ANGLE_WIDTH = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jlt_in_if.sink    in_if,
  jlt_out_if.source out_if,
  jlt_cfg_if.sink   cfg_if
);

  // Velocity and acceleration are kept at 32 bits; products use 66-bit temporaries
  // formed from one multiplier with a 33 by 33 signed input.
  localparam int unsigned JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int unsigned VW = 32;
  localparam int unsigned PW = 66;

  // Configuration registers.
  logic [15:0] tick_period_q, omega_q, step_limit_q;
  logic [19:0] speed_first_q, speed_other_q;
  logic [23:0] accel_first_q, accel_other_q, accel_change_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q  <= 16'd524;
      omega_q        <= 16'd2560;
      speed_first_q  <= 20'd30720;
      speed_other_q  <= 20'd30720;
      accel_first_q  <= 24'd102400;
      accel_other_q  <= 24'd102400;
      accel_change_q <= 24'd8192;
      step_limit_q   <= 16'd512;
    end else if (cfg_if.valid) begin
      case (jlt_pkg::reg_e'(cfg_if.index))
        jlt_pkg::REG_TICK_PERIOD:  tick_period_q  <= cfg_if.data[15:0];
        jlt_pkg::REG_OMEGA:        omega_q        <= cfg_if.data[15:0];
        jlt_pkg::REG_SPEED_FIRST:  speed_first_q  <= cfg_if.data[19:0];
        jlt_pkg::REG_SPEED_OTHER:  speed_other_q  <= cfg_if.data[19:0];
        jlt_pkg::REG_ACCEL_FIRST:  accel_first_q  <= cfg_if.data;
        jlt_pkg::REG_ACCEL_OTHER:  accel_other_q  <= cfg_if.data;
        jlt_pkg::REG_ACCEL_CHANGE: accel_change_q <= cfg_if.data;
        jlt_pkg::REG_STEP_LIMIT:   step_limit_q   <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  // Joint state. JOINT_COUNT entries, each read at the joint counter.
  logic signed [ANGLE_WIDTH-1:0] goal_q [JOINT_COUNT];
  logic signed [ANGLE_WIDTH-1:0] cmd_q  [JOINT_COUNT];
  logic signed [VW-1:0]          vel_q  [JOINT_COUNT];
  logic signed [VW-1:0]          acc_q  [JOINT_COUNT];
  logic active_q, cont_q;

  // Sequencer and datapath registers.
  jlt_pkg::state_e state_q, state_d;
  logic [JW-1:0]   idx_q;
  logic            reached_q, err_q;
  logic signed [PW-1:0] prod_q;     // registered multiplier output
  logic signed [PW-1:0] p_q;        // omega * delta
  logic signed [PW-1:0] wv_q;       // 512 * omega * vel
  logic [31:0]          w2_q;       // omega squared
  logic signed [VW:0]   a_new_q, v_new_q;

  logic signed [32:0]  mul_a, mul_b;
  logic signed [PW-1:0] mul_y;
  assign mul_y = mul_a * mul_b;

  // Current joint values.
  logic signed [ANGLE_WIDTH-1:0] goal_c, cmd_c;
  logic signed [VW-1:0]          vel_c, acc_c;
  logic signed [ANGLE_WIDTH:0]   delta_c;
  logic signed [PW-1:0]          vmax_c, amax_c, jmax_c;
  assign goal_c  = goal_q[idx_q];
  assign cmd_c   = cmd_q[idx_q];
  assign vel_c   = vel_q[idx_q];
  assign acc_c   = acc_q[idx_q];
  assign delta_c = (ANGLE_WIDTH+1)'(goal_c) - (ANGLE_WIDTH+1)'(cmd_c);
  assign vmax_c  = (idx_q == '0) ? PW'(speed_first_q) : PW'(speed_other_q);
  assign amax_c  = (idx_q == '0) ? PW'(accel_first_q) : PW'(accel_other_q);
  assign jmax_c  = PW'(accel_change_q);

  function automatic logic signed [PW-1:0] clampf(logic signed [PW-1:0] x,
                                                 logic signed [PW-1:0] lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic logic signed [PW-1:0] rnd16(logic signed [PW-1:0] x);
    return (x + PW'(32768)) >>> 16;
  endfunction

  function automatic logic signed [PW-1:0] absf(logic signed [PW-1:0] x);
    return (x < 0) ? -x : x;
  endfunction

  logic settle_c;
  assign settle_c = absf(PW'(delta_c)) <= PW'(jlt_pkg::SettleEps)
                 && absf(PW'(vel_c)) <= PW'(jlt_pkg::VelEps)
                 && absf(PW'(acc_c)) <= jmax_c;

  // Desired acceleration from the registered product omega * p.
  logic signed [PW-1:0] desired_c, a_tmp_c, v_tmp_c, step_c, cmd_sum_c;
  logic                 pass_c;
  always_comb begin
    if (p_q > (PW'(1) <<< 46)) desired_c = amax_c;
    else if (p_q < -(PW'(1) <<< 46)) desired_c = -amax_c;
    else desired_c = clampf(rnd16(prod_q - wv_q), amax_c);
    a_tmp_c   = clampf(PW'(acc_c) + clampf(desired_c - PW'(acc_c), jmax_c), amax_c);
    v_tmp_c   = clampf(PW'(vel_c) + rnd16(prod_q), vmax_c);
    step_c    = clampf(rnd16(prod_q), PW'(step_limit_q));
    pass_c    = (delta_c > 0 && step_c >= PW'(delta_c))
             || (delta_c < 0 && step_c <= PW'(delta_c));
    cmd_sum_c = PW'(cmd_c) + step_c;
  end

  localparam logic signed [PW-1:0] AngMax = PW'((64'sd1 <<< (ANGLE_WIDTH-1)) - 1);
  localparam logic signed [PW-1:0] AngMin = -PW'(64'sd1 <<< (ANGLE_WIDTH-1));

  logic in_fire, last_idx;
  assign in_fire  = in_if.valid && in_if.ready;
  assign last_idx = (idx_q == JW'(JOINT_COUNT - 1));

  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      jlt_pkg::ST_IDLE: begin
        if (in_fire && in_if.kind == jlt_pkg::KIND_TICK && active_q) begin
          state_d = jlt_pkg::ST_CHECK;
        end
      end
      jlt_pkg::ST_CHECK: begin
        // Omega squared is formed here for the later omega * p step.
        mul_a = 33'(signed'({1'b0, omega_q}));
        mul_b = 33'(signed'({1'b0, omega_q}));
        state_d = settle_c ? jlt_pkg::ST_EMIT : jlt_pkg::ST_MUL_P;
      end
      jlt_pkg::ST_MUL_P: begin
        mul_a = 33'(signed'({1'b0, omega_q}));
        mul_b = 33'(delta_c);
        state_d = jlt_pkg::ST_MUL_WV;
      end
      jlt_pkg::ST_MUL_WV: begin
        mul_a = 33'(signed'({1'b0, omega_q})) <<< 9;
        mul_b = 33'(vel_c);
        state_d = jlt_pkg::ST_MUL_WP;
      end
      jlt_pkg::ST_MUL_WP: begin
        // Omega * p is taken as omega squared times delta, so both inputs fit 33 bits.
        mul_a = 33'(signed'({1'b0, w2_q}));
        mul_b = 33'(delta_c);
        state_d = jlt_pkg::ST_DESIRED;
      end
      jlt_pkg::ST_DESIRED: state_d = jlt_pkg::ST_MUL_AT;
      jlt_pkg::ST_MUL_AT: begin
        mul_a = a_new_q;
        mul_b = 33'(signed'({1'b0, tick_period_q}));
        state_d = jlt_pkg::ST_VEL;
      end
      jlt_pkg::ST_VEL: state_d = jlt_pkg::ST_MUL_VT;
      jlt_pkg::ST_MUL_VT: begin
        mul_a = v_new_q;
        mul_b = 33'(signed'({1'b0, tick_period_q}));
        state_d = jlt_pkg::ST_STEP;
      end
      jlt_pkg::ST_STEP: state_d = jlt_pkg::ST_EMIT;
      jlt_pkg::ST_EMIT: begin
        // All joints are updated first; results stream out afterwards.
        if (!last_idx) state_d = jlt_pkg::ST_CHECK;
        else state_d = jlt_pkg::ST_IDLE;
      end
      default: state_d = jlt_pkg::ST_IDLE;
    endcase
  end

  // Output stage: after the last joint is computed, results drain from cmd_q.
  logic         draining_q;
  logic [JW-1:0] out_idx_q;
  logic         res_at_q, res_act_q;

  assign out_if.valid         = draining_q;
  assign out_if.out_joint     = 3'(out_idx_q);
  assign out_if.command_pos   = cmd_q[out_idx_q];
  assign out_if.status        = err_q;
  assign out_if.at_target     = res_at_q;
  assign out_if.motion_active = res_act_q;
  assign out_if.last          = (out_idx_q == JW'(JOINT_COUNT - 1));

  // Hold input off while results drain.
  assign in_if.ready = (state_q == jlt_pkg::ST_IDLE) && !draining_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= jlt_pkg::ST_IDLE;
      idx_q      <= '0;
      out_idx_q  <= '0;
      draining_q <= 1'b0;
      active_q   <= 1'b0;
      cont_q     <= 1'b0;
      reached_q  <= 1'b0;
      err_q      <= 1'b0;
      res_at_q   <= 1'b0;
      res_act_q  <= 1'b0;
      prod_q     <= '0;
      p_q        <= '0;
      wv_q       <= '0;
      w2_q       <= '0;
      a_new_q    <= '0;
      v_new_q    <= '0;
      for (int i = 0; i < JOINT_COUNT; i++) begin
        goal_q[i] <= '0;
        cmd_q[i]  <= '0;
        vel_q[i]  <= '0;
        acc_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      prod_q  <= mul_y;
      case (state_q)
        jlt_pkg::ST_IDLE: begin
          if (in_fire) begin
            idx_q     <= '0;
            reached_q <= 1'b1;
            err_q     <= !in_if.link_ok;
            case (jlt_pkg::kind_e'(in_if.kind))
              jlt_pkg::KIND_LOAD: begin
                if (32'(in_if.joint) < JOINT_COUNT) begin
                  goal_q[JW'(in_if.joint)] <= in_if.target_pos;
                  cont_q    <= in_if.continuous;
                  if (!active_q) begin
                    cmd_q[JW'(in_if.joint)] <= in_if.current_pos;
                    vel_q[JW'(in_if.joint)] <= '0;
                    acc_q[JW'(in_if.joint)] <= '0;
                    if (in_if.last_joint && in_if.link_ok) active_q <= 1'b1;
                  end
                end
              end
              jlt_pkg::KIND_STOP: begin
                for (int i = 0; i < JOINT_COUNT; i++) begin
                  vel_q[i] <= '0;
                  acc_q[i] <= '0;
                end
                active_q  <= 1'b0;
                cont_q    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        jlt_pkg::ST_CHECK: begin
          if (settle_c) begin
            cmd_q[idx_q] <= goal_c;
            vel_q[idx_q] <= '0;
            acc_q[idx_q] <= '0;
          end else begin
            reached_q <= 1'b0;
          end
        end
        jlt_pkg::ST_MUL_P: w2_q <= prod_q[31:0];
        jlt_pkg::ST_MUL_WV: p_q <= prod_q;
        jlt_pkg::ST_MUL_WP: wv_q <= prod_q;
        jlt_pkg::ST_DESIRED: a_new_q <= (VW+1)'(a_tmp_c);
        jlt_pkg::ST_VEL: v_new_q <= (VW+1)'(v_tmp_c);
        jlt_pkg::ST_STEP: begin
          if (pass_c) begin
            cmd_q[idx_q] <= goal_c;
            vel_q[idx_q] <= '0;
            acc_q[idx_q] <= '0;
          end else begin
            if (cmd_sum_c > AngMax) cmd_q[idx_q] <= AngMax[ANGLE_WIDTH-1:0];
            else if (cmd_sum_c < AngMin) cmd_q[idx_q] <= AngMin[ANGLE_WIDTH-1:0];
            else cmd_q[idx_q] <= cmd_sum_c[ANGLE_WIDTH-1:0];
            vel_q[idx_q] <= v_new_q[VW-1:0];
            acc_q[idx_q] <= a_new_q[VW-1:0];
          end
        end
        jlt_pkg::ST_EMIT: begin
          if (!last_idx) begin
            idx_q <= idx_q + JW'(1);
          end else begin
            // Apply the tick's flag updates, then stream the results.
            draining_q <= 1'b1;
            out_idx_q  <= '0;
            if (err_q) begin
              res_at_q  <= 1'b0;
              res_act_q <= 1'b0;
              active_q  <= 1'b0;
              cont_q    <= 1'b0;
              for (int i = 0; i < JOINT_COUNT; i++) begin
                vel_q[i] <= '0;
                acc_q[i] <= '0;
              end
            end else begin
              res_at_q  <= reached_q;
              if (reached_q && !cont_q) begin
                res_act_q <= 1'b0;
                active_q  <= 1'b0;
                cont_q    <= 1'b0;
                for (int i = 0; i < JOINT_COUNT; i++) begin
                  vel_q[i] <= '0;
                  acc_q[i] <= '0;
                end
              end else begin
                res_act_q <= active_q;
              end
            end
          end
        end
        default: ;
      endcase
      if (draining_q && out_if.ready) begin
        if (out_idx_q == JW'(JOINT_COUNT - 1)) draining_q <= 1'b0;
        else out_idx_q <= out_idx_q + JW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the jerk-limited joint tracker.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Joints = 6;
  localparam int unsigned AngW   = 24;
  // Quiet time for drain, sized from a tick's walk over the joints with room on top.
  localparam int unsigned DrainCycles = 10 * Joints + 20;

  // One expected command beat.
  typedef struct packed {
    logic [2:0]      joint;
    logic [AngW-1:0] cmd;
    logic            status;
    logic            at_target;
    logic            motion;
    logic            last;
  } cmd_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jlt_in_if  #(.AngleWidth(AngW)) in_bus ();
  jlt_out_if #(.AngleWidth(AngW)) out_bus ();
  jlt_cfg_if                      cfg_bus ();

  jerk_limited_joint_tracker #(.JOINT_COUNT(Joints), .ANGLE_WIDTH(AngW)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_bus),
    .out_if(out_bus),
    .cfg_if(cfg_bus)
  );

  always #6 clk = ~clk;

  // The tracker model: registers, per-joint motion state and the mode flags.
  longint tick_dt, omega_q, vmax_first, vmax_other, amax_first, amax_other;
  longint jerk_step, step_max;
  longint goal_q[Joints];
  longint cmd_q[Joints];
  longint vel_q[Joints];
  longint acc_q[Joints];
  bit     moving, stream_mode, settled;

  cmd_beat_t cmd_expect_q[$];
  int        mismatches = 0;
  bit        no_idle = 1'b0;

  // Rescale with half an LSB added; the arithmetic shift floors toward -infinity.
  function automatic longint rnd_shr16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic void halt_motion();
    for (int i = 0; i < Joints; i++) begin
      vel_q[i] = 0;
      acc_q[i] = 0;
    end
    moving = 1'b0;
    stream_mode = 1'b0;
    settled = 1'b0;
  endfunction

  // One tracker update for joint i; returns 1 when the joint is settled.
  function automatic bit advance_joint(int i);
    longint vmax, amax, v, a, delta, p, desired, stp, c;
    vmax = (i == 0) ? vmax_first : vmax_other;
    amax = (i == 0) ? amax_first : amax_other;
    v = vel_q[i];
    a = acc_q[i];
    delta = goal_q[i] - cmd_q[i];
    if (mag(delta) <= jlt_pkg::SettleEps && mag(v) <= jlt_pkg::VelEps
        && mag(a) <= jerk_step) begin
      cmd_q[i] = goal_q[i];
      vel_q[i] = 0;
      acc_q[i] = 0;
      return 1'b1;
    end
    p = omega_q * delta;
    if (p > (64'sd1 <<< 46)) desired = amax;
    else if (p < -(64'sd1 <<< 46)) desired = -amax;
    else desired = clip(rnd_shr16(omega_q * p - 512 * omega_q * v), amax);
    a = clip(a + clip(desired - a, jerk_step), amax);
    v = clip(v + rnd_shr16(a * tick_dt), vmax);
    stp = clip(rnd_shr16(v * tick_dt), step_max);
    if ((delta > 0 && stp >= delta) || (delta < 0 && stp <= delta)) begin
      // The step would reach or pass the goal, so the joint lands on it.
      cmd_q[i] = goal_q[i];
      v = 0;
      a = 0;
    end else begin
      c = cmd_q[i] + stp;
      if (c > 64'sd8388607) c = 64'sd8388607;
      if (c < -64'sd8388608) c = -64'sd8388608;
      cmd_q[i] = c;
    end
    vel_q[i] = v;
    acc_q[i] = a;
    return 1'b0;
  endfunction

  // Update the model for one accepted item and queue the command beats it causes.
  function automatic void predict_commands(jlt_pkg::kind_e k, logic [2:0] j,
                                           logic signed [AngW-1:0] tgt,
                                           logic signed [AngW-1:0] cur, bit cont, bit lastj,
                                           bit lok);
    bit reached;
    cmd_beat_t b;
    if (k == jlt_pkg::KIND_LOAD) begin
      if (j >= Joints) return;
      goal_q[j] = longint'(tgt);
      stream_mode = cont;
      settled = 1'b0;
      if (moving) return;
      cmd_q[j] = longint'(cur);
      vel_q[j] = 0;
      acc_q[j] = 0;
      if (lastj && lok) moving = 1'b1;
      return;
    end
    if (k == jlt_pkg::KIND_STOP) begin
      halt_motion();
      return;
    end
    if (k != jlt_pkg::KIND_TICK || !moving) return;
    reached = 1'b1;
    for (int i = 0; i < Joints; i++)
      if (!advance_joint(i)) reached = 1'b0;
    if (!lok) begin
      halt_motion();
      reached = 1'b0;
    end else begin
      settled = reached;
      if (reached && !stream_mode) halt_motion();
    end
    for (int i = 0; i < Joints; i++) begin
      b.joint = 3'(i);
      b.cmd = cmd_q[i][AngW-1:0];
      b.status = !lok;
      b.at_target = reached;
      b.motion = moving;
      b.last = (i == Joints - 1);
      cmd_expect_q.push_back(b);
    end
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item; valid is only lowered when a gap follows the previous beat.
  task automatic send_item(jlt_pkg::kind_e k, logic [2:0] j, logic signed [AngW-1:0] tgt,
                           logic signed [AngW-1:0] cur, bit cont, bit lastj, bit lok);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.kind        <= k;
    in_bus.joint       <= j;
    in_bus.target_pos  <= tgt;
    in_bus.current_pos <= cur;
    in_bus.continuous  <= cont;
    in_bus.last_joint  <= lastj;
    in_bus.link_ok     <= lok;
    do @(posedge clk); while (!in_bus.ready);
    predict_commands(k, j, tgt, cur, cont, lastj, lok);
  endtask

  task automatic send_tick(bit lok);
    send_item(jlt_pkg::KIND_TICK, 3'($urandom), AngW'($urandom), AngW'($urandom),
              1'($urandom), 1'($urandom), lok);
  endtask

  task automatic send_stop();
    send_item(jlt_pkg::KIND_STOP, 3'($urandom), AngW'($urandom), AngW'($urandom),
              1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Load all joints around a base angle; the final load starts motion.
  task automatic load_set(longint base, longint spread, bit cont, bit lok);
    longint cur;
    for (int i = 0; i < Joints; i++) begin
      cur = base + $signed($urandom_range(0, 2 * spread)) - spread;
      send_item(jlt_pkg::KIND_LOAD, 3'(i),
                AngW'(cur + $signed($urandom_range(0, 2 * spread)) - spread),
                AngW'(cur), cont, i == Joints - 1, lok);
    end
  endtask

  // Wait until every expected beat has arrived and the block has gone quiet.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(jlt_pkg::reg_e idx, logic [jlt_pkg::CfgDataW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      jlt_pkg::REG_TICK_PERIOD:  tick_dt    = value[15:0];
      jlt_pkg::REG_OMEGA:        omega_q    = value[15:0];
      jlt_pkg::REG_SPEED_FIRST:  vmax_first = value[19:0];
      jlt_pkg::REG_SPEED_OTHER:  vmax_other = value[19:0];
      jlt_pkg::REG_ACCEL_FIRST:  amax_first = value[23:0];
      jlt_pkg::REG_ACCEL_OTHER:  amax_other = value[23:0];
      jlt_pkg::REG_ACCEL_CHANGE: jerk_step  = value[23:0];
      jlt_pkg::REG_STEP_LIMIT:   step_max   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all_regs(longint dt, longint w, longint vf, longint vo, longint af,
                              longint ao, longint jc, longint sl);
    write_reg(jlt_pkg::REG_TICK_PERIOD, jlt_pkg::CfgDataW'(dt));
    write_reg(jlt_pkg::REG_OMEGA, jlt_pkg::CfgDataW'(w));
    write_reg(jlt_pkg::REG_SPEED_FIRST, jlt_pkg::CfgDataW'(vf));
    write_reg(jlt_pkg::REG_SPEED_OTHER, jlt_pkg::CfgDataW'(vo));
    write_reg(jlt_pkg::REG_ACCEL_FIRST, jlt_pkg::CfgDataW'(af));
    write_reg(jlt_pkg::REG_ACCEL_OTHER, jlt_pkg::CfgDataW'(ao));
    write_reg(jlt_pkg::REG_ACCEL_CHANGE, jlt_pkg::CfgDataW'(jc));
    write_reg(jlt_pkg::REG_STEP_LIMIT, jlt_pkg::CfgDataW'(sl));
    cfg_bus.valid <= 1'b0;
  endtask

  // Reset values, exercised before any register is touched.
  task automatic test_reset_defaults();
    load_set(0, 2000, 1'b0, 1'b1);
    repeat (8) send_tick(1'b1);
    send_stop();
    drain();
  endtask

  // Ignored items, refused starts, link failure, reaching the goal and streaming.
  task automatic test_special_cases();
    send_tick(1'b1);                                         // tick while idle
    send_item(jlt_pkg::KIND_NONE, 3'd0, 24'sd5, 24'sd5, 1'b0, 1'b1, 1'b1);
    send_item(jlt_pkg::KIND_LOAD, 3'd6, 24'sd100, 24'sd0, 1'b0, 1'b1, 1'b1);
    send_item(jlt_pkg::KIND_LOAD, 3'd7, -24'sd100, 24'sd0, 1'b1, 1'b1, 1'b1);
    load_set(500, 50, 1'b0, 1'b0);                           // start refused by the link
    send_tick(1'b1);
    // Goals equal to the commands settle on the first tick and end the motion.
    for (int i = 0; i < Joints; i++)
      send_item(jlt_pkg::KIND_LOAD, 3'(i), 24'sd300, 24'sd300, 1'b0, i == Joints - 1, 1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    // Streaming mode keeps motion alive after the goal is reached.
    for (int i = 0; i < Joints; i++)
      send_item(jlt_pkg::KIND_LOAD, 3'(i), 24'sd8388607, 24'sd8388600, 1'b1,
                i == Joints - 1, 1'b1);
    repeat (4) send_tick(1'b1);
    // A load while moving only retargets the joint.
    send_item(jlt_pkg::KIND_LOAD, 3'd2, -24'sd8388608, 24'sd0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);                                         // link failure on a tick
    send_tick(1'b1);
    drain();
  endtask

  // Register extremes, each followed by a short motion, the first two also by a stop.
  task automatic test_config_extremes();
    set_all_regs(65535, 65535, 1048575, 1048575, 16777215, 16777215, 16777215, 65535);
    load_set(-8388000, 400, 1'b1, 1'b1);
    repeat (5) send_tick(1'b1);
    send_stop();
    drain();
    set_all_regs(1, 1, 0, 0, 0, 0, 0, 0);
    load_set(4000, 3000, 1'b0, 1'b1);
    repeat (3) send_tick(1'b1);
    send_stop();
    drain();
    set_all_regs(6000, 8000, 200000, 150000, 900000, 700000, 60000, 3000);
    load_set(0, 6000, 1'b0, 1'b1);
    repeat (6) send_tick(1'b1);
    drain();
  endtask

  // Random target sets with random content, plus noise and broken sequences.
  task automatic test_random_motion();
    int sent;
    int r;
    sent = 0;
    while (sent < 400) begin
      if ($urandom_range(0, 9) == 0) begin
        drain();
        no_idle = ($urandom_range(0, 3) == 0);
        set_all_regs($urandom_range(1, 65535), $urandom_range(1, 65535),
                     $urandom_range(0, 1048575), $urandom_range(0, 1048575),
                     $urandom_range(0, 16777215), $urandom_range(0, 16777215),
                     $urandom_range(0, 16777215), $urandom_range(0, 65535));
      end
      r = $urandom_range(0, 9);
      if (r < 7) begin
        if ($urandom_range(0, 4) == 0)
          load_set($signed($urandom) >>> 8, 8388607, 1'($urandom),
                   $urandom_range(0, 7) != 0);
        else
          load_set($signed($urandom) >>> 10, $urandom_range(5, 3000), 1'($urandom),
                   $urandom_range(0, 7) != 0);
        sent += Joints;
        for (int n = $urandom_range(1, 12); n > 0; n--) begin
          send_tick($urandom_range(0, 15) != 0);
          sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_stop();
          sent++;
        end
      end else begin
        // Noise: loose loads, including joints out of range, ticks, stops and kind 3.
        for (int n = $urandom_range(1, 6); n > 0; n--) begin
          send_item(jlt_pkg::kind_e'(2'($urandom)), 3'($urandom), AngW'($urandom),
                    AngW'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
          sent++;
        end
      end
    end
    drain();
  endtask

  // Result sink: random stalls on ready.
  initial begin : result_ready
    int hold;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        out_bus.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) hold = pick_gap();
      end else begin
        out_bus.ready <= 1'b0;
        hold--;
      end
    end
  end

  // Compare every accepted command beat with the oldest expectation.
  always @(posedge clk) begin : check_commands
    cmd_beat_t want;
    cmd_beat_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.out_joint, out_bus.command_pos, out_bus.status, out_bus.at_target,
             out_bus.motion_active, out_bus.last};
      if (cmd_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected command beat: %p", got);
      end else begin
        want = cmd_expect_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Command beat mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin : run_limit
    #50ms;
    $display("FAILURE");
    $finish;
  end

  // The drive side starts with every input at a known value.
  initial begin : main_seq
    in_bus.valid = 1'b0;
    in_bus.kind = jlt_pkg::KIND_NONE;
    in_bus.joint = '0;
    in_bus.target_pos = '0;
    in_bus.current_pos = '0;
    in_bus.continuous = 1'b0;
    in_bus.last_joint = 1'b0;
    in_bus.link_ok = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = jlt_pkg::REG_TICK_PERIOD;
    cfg_bus.data = '0;
    for (int i = 0; i < Joints; i++) begin
      goal_q[i] = 0;
      cmd_q[i] = 0;
    end
    halt_motion();
    tick_dt = 524;
    omega_q = 2560;
    vmax_first = 30720;
    vmax_other = 30720;
    amax_first = 102400;
    amax_other = 102400;
    jerk_step = 8192;
    step_max = 512;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_config_extremes();
    test_random_motion();
    if (mismatches == 0 && cmd_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
src/jlt_pkg.sv
src/jlt_if.sv
src/jerk_limited_joint_tracker.sv
tb/tb_top.sv
